// ----- hw/rtl/record_stack_top_defines.svh -----
// Assertion macros used by the record stack top RTL file.
`ifndef RECORD_STACK_TOP_DEFINES_SVH
`define RECORD_STACK_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside of reset.
`define RSTK_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define RSTK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RSTK_ASSERT_IMPL(lbl, ante, cons, msg)
`define RSTK_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/rstk_pkg.sv -----
// Shared constants and types of the record stack.
package rstk_pkg;

	// Storage sizing.
	localparam int DATA_DEPTH     = 1024;
	localparam int MAX_RECORDS    = 256;
	localparam int MAX_RECORD_LEN = 64;
	localparam int DATA_WIDTH     = 32;

	// Derived widths.
	localparam int ADDR_W    = $clog2(DATA_DEPTH);
	localparam int PTR_W     = $clog2(DATA_DEPTH + 1);
	localparam int REC_IDX_W = $clog2(MAX_RECORDS);
	localparam int CNT_W     = $clog2(MAX_RECORDS + 1);
	localparam int LEN_W     = $clog2(MAX_RECORD_LEN + 1);

	// Output queue sizing.
	localparam int OUT_DEPTH  = 4;
	localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
	localparam int OUT_LVL_W  = $clog2(OUT_DEPTH + 1);
	localparam int PEND_W     = OUT_LVL_W + 1;

	// Command codes.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STAT_ELEM  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// One result word as it enters the output queue.
	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  last;
		logic [1:0]            status;
	} out_word_t;

endpackage

// ----- hw/rtl/rstk_out_fifo.sv -----
// Small output queue that decouples result production from the consumer.
module rstk_out_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  rstk_pkg::out_word_t                wr_word,
	output logic [rstk_pkg::OUT_LVL_W-1:0]     level,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [rstk_pkg::DATA_WIDTH-1:0] value_out,
	output logic                               last_out,
	output logic [1:0]                         status
);
	import rstk_pkg::*;

	out_word_t             words_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  wr_ptr_q;
	logic [OUT_PTR_W-1:0]  rd_ptr_q;
	logic [OUT_LVL_W-1:0]  level_q;
	logic                  rd_en;

	// A word leaves when it is shown and not stalled.
	assign out_valid = (level_q != '0);
	assign rd_en     = out_valid && !out_stall;
	assign level     = level_q;

	assign value_out = $signed(words_q[rd_ptr_q].value);
	assign last_out  = words_q[rd_ptr_q].last;
	assign status    = words_q[rd_ptr_q].status;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			words_q[wr_ptr_q] <= wr_word;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			level_q <= level_q + OUT_LVL_W'(wr_en) - OUT_LVL_W'(rd_en);
		end
	end

endmodule

// ----- hw/rtl/record_stack_top.sv -----
// Last-in first-out stack of variable-length records (1 to 64 signed 32-bit words each, up to
// 256 records and 1024 words in all). A push word stores one element per cycle when in_stall
// is low and needs no result; the record is committed when its word marked last arrives, and
// a push that would exceed the record count, the storage or the length limit gives one full
// status and drops the rest of that record. A pop word reads the top record's start from the
// start memory, then streams the record one element per cycle while the output queue has room,
// from the element memory, oldest first, the last one marked; a pop on an empty stack gives
// one empty status. A pop also discards any record that is still open. Results pass through a
// four-word output queue, so the input side keeps accepting while a result waits to be taken.
`include "record_stack_top_defines.svh"

module record_stack_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   cmd,
	input  logic signed [rstk_pkg::DATA_WIDTH-1:0] value,
	input  logic                                   last_element,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [rstk_pkg::DATA_WIDTH-1:0] value_out,
	output logic                                   last_out,
	output logic [1:0]                             status
);
	import rstk_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_LEN    = 2'd1;
	localparam logic [1:0] S_STREAM = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [PTR_W-1:0]      wp_q;
	logic [LEN_W-1:0]      open_q;
	logic                  drop_q;
	logic [ADDR_W-1:0]     rd_ptr_q;
	logic [LEN_W-1:0]      remain_q;

	logic                  valid_s1;
	logic                  last_s1;
	logic [1:0]            status_s1;
	logic [DATA_WIDTH-1:0] elem_rd_s1;
	logic [ADDR_W-1:0]     rs_rd_q;

	logic [DATA_WIDTH-1:0] elem_mem [DATA_DEPTH];
	logic [ADDR_W-1:0]     rs_mem [MAX_RECORDS];

	logic [OUT_LVL_W-1:0]  fifo_level;
	logic [PEND_W-1:0]     pending;
	logic                  room;
	logic                  accept;
	logic                  push_acc;
	logic                  pop_acc;
	logic [PTR_W-1:0]      pos;
	logic                  full;
	logic                  elem_we;
	logic                  commit;
	logic                  rs_re;
	logic [CNT_W-1:0]      cnt_dec;
	logic [PTR_W-1:0]      len_calc;
	logic                  issue;
	out_word_t             fifo_word;

	// Queue space, counting a word that is still in the read stage.
	assign pending = PEND_W'(fifo_level) + PEND_W'(valid_s1);
	assign room    = (pending < PEND_W'(OUT_DEPTH));

	// Input handshake: words are taken only between pops and while the queue has room.
	assign in_stall = !((state_q == S_IDLE) && room);
	assign accept   = in_valid && !in_stall;
	assign push_acc = accept && (cmd == CMD_PUSH);
	assign pop_acc  = accept && (cmd == CMD_POP);

	// Push decode: where the element goes and whether it fits.
	assign pos     = wp_q + PTR_W'(open_q);
	assign full    = (count_q >= CNT_W'(MAX_RECORDS)) || (pos >= PTR_W'(DATA_DEPTH)) ||
	                 (open_q >= LEN_W'(MAX_RECORD_LEN));
	assign elem_we = push_acc && !drop_q && !full;
	assign commit  = elem_we && last_element;

	// Pop decode: top record index and its length once its start is read.
	assign rs_re    = pop_acc && (count_q != '0);
	assign cnt_dec  = count_q - CNT_W'(1);
	assign len_calc = wp_q - PTR_W'(rs_rd_q);
	assign issue    = (state_q == S_STREAM) && room;

	// Element memory: one write port for pushes, one registered read port for pops.
	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[pos[ADDR_W-1:0]] <= value;
		end
		if (issue) begin
			elem_rd_s1 <= elem_mem[rd_ptr_q];
		end
	end

	// Record start memory: written on commit, read at the start of a pop.
	always_ff @(posedge clk) begin
		if (commit) begin
			rs_mem[count_q[REC_IDX_W-1:0]] <= wp_q[ADDR_W-1:0];
		end
		if (rs_re) begin
			rs_rd_q <= rs_mem[cnt_dec[REC_IDX_W-1:0]];
		end
	end

	// Control sequencer and the result stage that feeds the output queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			wp_q      <= '0;
			open_q    <= '0;
			drop_q    <= 1'b0;
			rd_ptr_q  <= '0;
			remain_q  <= '0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
			status_s1 <= STAT_ELEM;
		end else begin
			valid_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (push_acc) begin
						if (drop_q) begin
							if (last_element) begin
								drop_q <= 1'b0;
							end
						end else if (full) begin
							open_q    <= '0;
							drop_q    <= !last_element;
							valid_s1  <= 1'b1;
							last_s1   <= 1'b1;
							status_s1 <= STAT_FULL;
						end else if (last_element) begin
							wp_q    <= pos + PTR_W'(1);
							count_q <= count_q + CNT_W'(1);
							open_q  <= '0;
						end else begin
							open_q <= open_q + LEN_W'(1);
						end
					end else if (pop_acc) begin
						open_q <= '0;
						drop_q <= 1'b0;
						if (count_q == '0) begin
							valid_s1  <= 1'b1;
							last_s1   <= 1'b1;
							status_s1 <= STAT_EMPTY;
						end else begin
							state_q <= S_LEN;
						end
					end
				end
				S_LEN: begin
					rd_ptr_q <= rs_rd_q;
					remain_q <= len_calc[LEN_W-1:0];
					wp_q     <= PTR_W'(rs_rd_q);
					count_q  <= cnt_dec;
					state_q  <= S_STREAM;
				end
				S_STREAM: begin
					if (issue) begin
						valid_s1  <= 1'b1;
						last_s1   <= (remain_q == LEN_W'(1));
						status_s1 <= STAT_ELEM;
						rd_ptr_q  <= rd_ptr_q + ADDR_W'(1);
						remain_q  <= remain_q - LEN_W'(1);
						if (remain_q == LEN_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Status results carry a zero value.
	assign fifo_word.value  = (status_s1 == STAT_ELEM) ? elem_rd_s1 : '0;
	assign fifo_word.last   = last_s1;
	assign fifo_word.status = status_s1;

	rstk_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (valid_s1),
		.wr_word   (fifo_word),
		.level     (fifo_level),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_out (value_out),
		.last_out  (last_out),
		.status    (status)
	);

	// The result stage only writes when the queue has a free slot.
	`RSTK_ASSERT_IMPL(a_queue_has_slot, valid_s1, fifo_level < OUT_LVL_W'(OUT_DEPTH), "output queue overrun")
	// The committed word count never passes the storage size.
	`RSTK_ASSERT_IMPL(a_wp_in_range, 1'b1, wp_q <= PTR_W'(DATA_DEPTH), "write pointer out of range")
	// A pop only fetches a length when a record exists.
	`RSTK_ASSERT_IMPL(a_len_has_record, state_q == S_LEN, count_q != '0, "length fetch with no record")
	// The final element read of a pop returns the sequencer to idle.
	`RSTK_ASSERT_NEXT(a_last_read_ends_pop, issue && (remain_q == LEN_W'(1)), state_q == S_IDLE, "pop did not end")
	// While a record is being dropped nothing is left open.
	`RSTK_ASSERT_IMPL(a_drop_no_open, drop_q, open_q == '0, "open record while dropping")

endmodule
